@@ src/wgia_pkg.sv @@
// Shared types and constants for the width generic integer ALU.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package wgia_pkg;

   localparam int DATA_WIDTH    = 64;
   localparam int MAX_WIDTH_DEF = 64;
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [4:0] {
      OP_ADD    = 5'd0,
      OP_SUB    = 5'd1,
      OP_AND    = 5'd2,
      OP_OR     = 5'd3,
      OP_XOR    = 5'd4,
      OP_MUL    = 5'd5,
      OP_DIV    = 5'd6,
      OP_MOD    = 5'd7,
      OP_SHL    = 5'd8,
      OP_SHR    = 5'd9,
      OP_SLT    = 5'd10,
      OP_SGT    = 5'd11,
      OP_SLE    = 5'd12,
      OP_SGE    = 5'd13,
      OP_EQ     = 5'd14,
      OP_NE     = 5'd15,
      OP_ULT    = 5'd16,
      OP_UGT    = 5'd17,
      OP_ULE    = 5'd18,
      OP_UGE    = 5'd19,
      OP_NEG    = 5'd20,
      OP_PLUS   = 5'd21,
      OP_LOGNOT = 5'd22,
      OP_BITNOT = 5'd23,
      OP_CAST   = 5'd24
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_SHIFT    = 2'd1,
      STAT_DIVZERO  = 2'd2,
      STAT_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_MUL,
      BK_DIV,
      BK_FIN
   } back_state_type;

   typedef struct packed {
      logic [4:0]            mode;
      logic [DATA_WIDTH-1:0] left_value;
      logic [DATA_WIDTH-1:0] right_value;
      logic [6:0]            type_width;
      logic                  type_unsigned;
      logic [6:0]            target_width;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] result;
      logic                  folded;
      logic [1:0]            status;
   } rsp_type;

   typedef struct packed {
      op_type                op;
      logic                  uns;
      logic [DATA_WIDTH-1:0] l;
      logic [DATA_WIDTH-1:0] r;
      logic [DATA_WIDTH-1:0] sl;
      logic [DATA_WIDTH-1:0] sr;
      logic [DATA_WIDTH-1:0] dva;
      logic [DATA_WIDTH-1:0] dvb;
      logic [DATA_WIDTH-1:0] mask;
      logic [5:0]            shamt;
      logic                  neg_res;
      logic                  kill;
      status_type            status;
   } dec_type;

endpackage

@@ src/wgia_front.sv @@
// Front end: clamps widths, masks and sign-extends operands, and flags special cases.
// Depends on wgia_pkg.
`timescale 1ns / 1ps

module wgia_front #(
   parameter int MAX_WIDTH = wgia_pkg::MAX_WIDTH_DEF
) (
   input  wgia_pkg::req_type req,
   output wgia_pkg::dec_type dec
);

   logic [6:0]  w;
   logic [6:0]  tw;
   logic [63:0] m;
   logic [63:0] tm;
   logic [63:0] l;
   logic [63:0] r;
   logic [63:0] sl;
   logic [63:0] sr;
   logic [63:0] minv;
   logic [5:0]  wm1;
   logic        too_big;
   logic        lneg;
   logic        rneg;

   always_comb begin
      if (req.type_width == 7'd0) begin
         w = 7'd1;
      end else if (req.type_width > 7'(MAX_WIDTH)) begin
         w = 7'(MAX_WIDTH);
      end else begin
         w = req.type_width;
      end
      if (req.target_width == 7'd0) begin
         tw = 7'd1;
      end else if (req.target_width > 7'(MAX_WIDTH)) begin
         tw = 7'(MAX_WIDTH);
      end else begin
         tw = req.target_width;
      end
      m    = {64{1'b1}} >> (7'd64 - w);
      tm   = {64{1'b1}} >> (7'd64 - tw);
      wm1  = 6'(w - 7'd1);
      l    = req.left_value & m;
      r    = req.right_value & m;
      lneg = l[wm1];
      rneg = r[wm1];
      sl   = lneg ? (l | ~m) : l;
      sr   = rneg ? (r | ~m) : r;
      minv = 64'd1 << wm1;
      too_big = (req.right_value[63:7] != 57'd0) || (req.right_value[6:0] >= w);

      dec.op      = wgia_pkg::op_type'(req.mode);
      dec.uns     = req.type_unsigned;
      dec.l       = l;
      dec.r       = r;
      dec.sl      = sl;
      dec.sr      = sr;
      dec.dva     = (req.type_unsigned || !lneg) ? l : (64'd0 - sl);
      dec.dvb     = (req.type_unsigned || !rneg) ? r : (64'd0 - sr);
      dec.mask    = (req.mode == 5'(wgia_pkg::OP_CAST)) ? tm : m;
      dec.shamt   = too_big ? (req.right_value[5:0] & wm1) : req.right_value[5:0];
      dec.neg_res = 1'b0;
      dec.kill    = 1'b0;
      dec.status  = wgia_pkg::STAT_OK;

      if (req.mode > 5'(wgia_pkg::OP_CAST)) begin
         dec.op   = wgia_pkg::OP_ADD;
         dec.kill = 1'b1;
      end else begin
         unique case (wgia_pkg::op_type'(req.mode))
            wgia_pkg::OP_DIV, wgia_pkg::OP_MOD: begin
               dec.neg_res = (req.mode == 5'(wgia_pkg::OP_DIV)) ?
                             (!req.type_unsigned && (lneg ^ rneg)) :
                             (!req.type_unsigned && lneg);
               if (r == 64'd0) begin
                  dec.kill   = 1'b1;
                  dec.status = wgia_pkg::STAT_DIVZERO;
               end else if (req.mode == 5'(wgia_pkg::OP_DIV) && !req.type_unsigned &&
                            l == minv && sr == {64{1'b1}}) begin
                  dec.kill   = 1'b1;
                  dec.status = wgia_pkg::STAT_OVERFLOW;
               end
            end
            wgia_pkg::OP_SHL, wgia_pkg::OP_SHR: begin
               if (too_big) begin
                  dec.status = wgia_pkg::STAT_SHIFT;
               end
            end
            wgia_pkg::OP_NEG: begin
               if (!req.type_unsigned && l == minv) begin
                  dec.kill   = 1'b1;
                  dec.status = wgia_pkg::STAT_OVERFLOW;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

@@ src/wgia_queue.sv @@
// Two-word queue that decouples the front end from the execution back end.
// Depends on wgia_pkg.
`timescale 1ns / 1ps

module wgia_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wgia_pkg::dec_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output wgia_pkg::dec_type head_data
);

   wgia_pkg::dec_type mem_ff [wgia_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      full       = (count_ff == 2'(wgia_pkg::QUEUE_DEPTH));
      head_valid = (count_ff != 2'd0);
      head_data  = mem_ff[rd_ptr_ff];
      wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(wgia_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> !full)
      else $error("queue pushed while full");

endmodule

@@ src/wgia_back.sv @@
// Back end: combinational ALU, sequential 32x32 multiplier and radix-2 divider,
// and the result register. Depends on wgia_pkg.
`timescale 1ns / 1ps

module wgia_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  wgia_pkg::dec_type head_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wgia_pkg::rsp_type rsp_data
);

   wgia_pkg::back_state_type state_ff;
   wgia_pkg::back_state_type state_in;
   wgia_pkg::dec_type        hold_ff;
   wgia_pkg::dec_type        hold_in;
   logic [63:0]              acc_ff;
   logic [63:0]              acc_in;
   logic [63:0]              rem_ff;
   logic [63:0]              rem_in;
   logic [5:0]               step_ff;
   logic [5:0]               step_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   wgia_pkg::rsp_type        rsp_data_ff;
   wgia_pkg::rsp_type        rsp_data_in;

   logic                     out_free;
   logic                     is_seq;
   logic [63:0]              simple_v;
   logic [31:0]              mul_a;
   logic [31:0]              mul_b;
   logic [63:0]              prod;
   logic [64:0]              trial;
   logic                     ge;
   logic [64:0]              diff;
   logic [63:0]              fin_v;

   always_comb begin
      unique case (head_data.op)
         wgia_pkg::OP_ADD:    simple_v = head_data.l + head_data.r;
         wgia_pkg::OP_SUB:    simple_v = head_data.l - head_data.r;
         wgia_pkg::OP_AND:    simple_v = head_data.l & head_data.r;
         wgia_pkg::OP_OR:     simple_v = head_data.l | head_data.r;
         wgia_pkg::OP_XOR:    simple_v = head_data.l ^ head_data.r;
         wgia_pkg::OP_SHL:    simple_v = head_data.l << head_data.shamt;
         wgia_pkg::OP_SHR:    simple_v = head_data.uns ? (head_data.l >> head_data.shamt) :
                                         64'($signed(head_data.sl) >>> head_data.shamt);
         wgia_pkg::OP_SLT:    simple_v = 64'($signed(head_data.sl) < $signed(head_data.sr));
         wgia_pkg::OP_SGT:    simple_v = 64'($signed(head_data.sl) > $signed(head_data.sr));
         wgia_pkg::OP_SLE:    simple_v = 64'($signed(head_data.sl) <= $signed(head_data.sr));
         wgia_pkg::OP_SGE:    simple_v = 64'($signed(head_data.sl) >= $signed(head_data.sr));
         wgia_pkg::OP_EQ:     simple_v = 64'(head_data.l == head_data.r);
         wgia_pkg::OP_NE:     simple_v = 64'(head_data.l != head_data.r);
         wgia_pkg::OP_ULT:    simple_v = 64'(head_data.l < head_data.r);
         wgia_pkg::OP_UGT:    simple_v = 64'(head_data.l > head_data.r);
         wgia_pkg::OP_ULE:    simple_v = 64'(head_data.l <= head_data.r);
         wgia_pkg::OP_UGE:    simple_v = 64'(head_data.l >= head_data.r);
         wgia_pkg::OP_NEG:    simple_v = 64'd0 - head_data.l;
         wgia_pkg::OP_PLUS:   simple_v = head_data.l;
         wgia_pkg::OP_LOGNOT: simple_v = 64'(head_data.l == 64'd0);
         wgia_pkg::OP_BITNOT: simple_v = ~head_data.l;
         wgia_pkg::OP_CAST:   simple_v = head_data.uns ? head_data.l : head_data.sl;
         default:             simple_v = 64'd0;
      endcase
   end

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      is_seq   = !head_data.kill && (head_data.op == wgia_pkg::OP_MUL ||
                 head_data.op == wgia_pkg::OP_DIV || head_data.op == wgia_pkg::OP_MOD);

      mul_a = (step_ff == 6'd2) ? hold_ff.l[63:32] : hold_ff.l[31:0];
      mul_b = (step_ff == 6'd1) ? hold_ff.r[63:32] : hold_ff.r[31:0];
      prod  = mul_a * mul_b;

      trial = {rem_ff, acc_ff[63]};
      diff  = trial - {1'b0, hold_ff.dvb};
      ge    = !diff[64];

      if (hold_ff.op == wgia_pkg::OP_MUL) begin
         fin_v = acc_ff;
      end else if (hold_ff.op == wgia_pkg::OP_DIV) begin
         fin_v = hold_ff.neg_res ? (64'd0 - acc_ff) : acc_ff;
      end else begin
         fin_v = hold_ff.neg_res ? (64'd0 - rem_ff) : rem_ff;
      end

      state_in     = state_ff;
      hold_in      = hold_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         wgia_pkg::BK_RUN: begin
            if (head_valid && is_seq) begin
               pop     = 1'b1;
               hold_in = head_data;
               step_in = 6'd0;
               if (head_data.op == wgia_pkg::OP_MUL) begin
                  state_in = wgia_pkg::BK_MUL;
               end else begin
                  state_in = wgia_pkg::BK_DIV;
                  acc_in   = head_data.dva;
                  rem_in   = 64'd0;
               end
            end else if (head_valid && out_free) begin
               pop                = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_data_in.result = head_data.kill ? 64'd0 : (simple_v & head_data.mask);
               rsp_data_in.folded = !head_data.kill;
               rsp_data_in.status = head_data.status;
            end
         end
         wgia_pkg::BK_MUL: begin
            if (step_ff == 6'd0) begin
               acc_in = prod;
            end else begin
               acc_in = acc_ff + {prod[31:0], 32'd0};
            end
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd2) begin
               state_in = wgia_pkg::BK_FIN;
            end
         end
         wgia_pkg::BK_DIV: begin
            rem_in  = ge ? diff[63:0] : trial[63:0];
            acc_in  = {acc_ff[62:0], ge};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               state_in = wgia_pkg::BK_FIN;
            end
         end
         wgia_pkg::BK_FIN: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.result = fin_v & hold_ff.mask;
               rsp_data_in.folded = 1'b1;
               rsp_data_in.status = hold_ff.status;
               state_in           = wgia_pkg::BK_RUN;
            end
         end
         default: begin
            state_in = wgia_pkg::BK_RUN;
         end
      endcase

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wgia_pkg::BK_RUN;
         rsp_valid_ff <= 1'b0;
         step_ff      <= 6'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_unfolded_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.folded) |-> (rsp_data_ff.result == 64'd0))
      else $error("unfolded word carries a nonzero result");
   a_divzero_unfolded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == wgia_pkg::STAT_DIVZERO) |-> !rsp_data_ff.folded)
      else $error("division by zero reported as folded");
   a_pop_only_in_run: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == wgia_pkg::BK_RUN))
      else $error("queue popped while a sequential operation is in progress");
   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wgia_pkg::BK_DIV && step_ff != 6'd63) |=> (state_ff == wgia_pkg::BK_DIV))
      else $error("divider left before its last step");

endmodule

@@ src/width_generic_integer_alu.sv @@
// Width generic integer ALU, top level: front end, queue and back end.
// Depends on wgia_pkg, wgia_front, wgia_queue and wgia_back.
//
// Each request word carries an operation code, two 64-bit operands, the
// operand type width and signedness, and a target width for casts. Each
// request yields exactly one response word with the result cut to the width,
// a folded flag and a status code, in request order.
// Both channels use valid and ready. The front end classifies a request in
// the cycle it is taken into a two-word queue; the back end executes it.
// Logic, shift, compare, add and cast operations pass through the queue and
// the response register and sustain one word per cycle while the receiver
// takes responses. Multiply uses one 32x32 multiplier; divide and modulo run
// a radix-2 divider of 64 steps. Both hold the back end until BK_FIN hands
// on the result. Operations that do not fold (division by zero, overflow,
// unused codes) take the ALU path. When the receiver stalls, the response
// register holds its word, the queue fills and req_ready falls.
// Reset empties the queue and the response register.
`timescale 1ns / 1ps

module width_generic_integer_alu #(
   parameter int MAX_WIDTH = wgia_pkg::MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wgia_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wgia_pkg::rsp_type rsp_data
);

   wgia_pkg::dec_type dec;
   wgia_pkg::dec_type head_data;
   logic              full;
   logic              head_valid;
   logic              pop;

   assign req_ready = !full;

   wgia_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .req(req_data),
      .dec(dec)
   );

   wgia_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(req_valid && !full),
      .push_data(dec),
      .full(full),
      .pop(pop),
      .head_valid(head_valid),
      .head_data(head_data)
   );

   wgia_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_data(head_data),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule
